// ===== rtl/core/sysex_usb_midi_packetizer_assert.svh =====
// Assertion macros shared by the SysEx packetizer RTL.
`ifndef SYSEX_USB_MIDI_PACKETIZER_ASSERT_SVH
`define SYSEX_USB_MIDI_PACKETIZER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SYSEX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define SYSEX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sysex_pkg.sv =====
// Types and code index constants for the SysEx USB-MIDI packetizer.
package sysex_pkg;

  localparam logic [3:0] CIN_ONLY_THREE = 4'h3;
  localparam logic [3:0] CIN_GROUP      = 4'h4;
  localparam logic [3:0] CIN_END_ONE    = 4'h5;
  localparam logic [3:0] CIN_END_TWO    = 4'h6;
  localparam logic [3:0] CIN_END_THREE  = 4'h7;

  typedef logic [1:0] count_t;

  typedef struct packed {
    logic [4:0] header;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;
    logic       last_packet;
  } pkt_t;

endpackage

// ===== rtl/core/sysex_ifs.sv =====
// Valid/ready channel interfaces for message bytes and event packets.
interface sysex_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface sysex_pkt_if;
  logic       valid;
  logic       ready;
  logic [4:0] header;
  logic [7:0] byte_one;
  logic [7:0] byte_two;
  logic [7:0] byte_three;
  logic       last_packet;

  modport source (output valid, output header, output byte_one, output byte_two,
                  output byte_three, output last_packet, input ready);
  modport sink (input valid, input header, input byte_one, input byte_two,
                input byte_three, input last_packet, output ready);
endinterface

// ===== rtl/core/sysex_grouper.sv =====
// Byte grouping state and packet formation for the SysEx packetizer.
`include "sysex_usb_midi_packetizer_assert.svh"

module sysex_grouper
  import sysex_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       is_last,
  input  logic       cable,
  output logic       pkt_valid,
  output pkt_t       pkt
);

  logic [7:0] pend0_r, pend1_r;
  count_t     count_r, count_nxt;
  logic       first_r, first_nxt;
  logic [3:0] code;

  always_comb begin
    pkt       = '0;
    pkt_valid = 1'b0;
    code      = CIN_GROUP;
    count_nxt = count_r;
    first_nxt = first_r;
    if (count_r == 2'd2) begin
      pkt_valid = 1'b1;
      if (is_last) begin
        code = first_r ? CIN_ONLY_THREE : CIN_END_THREE;
      end else begin
        code = CIN_GROUP;
      end
      pkt.byte_one    = pend0_r;
      pkt.byte_two    = pend1_r;
      pkt.byte_three  = data_byte;
      pkt.last_packet = is_last;
      count_nxt       = 2'd0;
      first_nxt       = is_last;
    end else if (is_last) begin
      pkt_valid = 1'b1;
      if (count_r == 2'd0) begin
        code         = CIN_END_ONE;
        pkt.byte_one = data_byte;
      end else begin
        code         = CIN_END_TWO;
        pkt.byte_one = pend0_r;
        pkt.byte_two = data_byte;
      end
      pkt.last_packet = 1'b1;
      count_nxt       = 2'd0;
      first_nxt       = 1'b1;
    end else begin
      count_nxt = count_r + 2'd1;
    end
    pkt.header = {cable, code};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
      first_r <= 1'b1;
    end else if (accept) begin
      count_r <= count_nxt;
      first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_last && count_r == 2'd0) begin
      pend0_r <= data_byte;
    end
    if (accept && !is_last && count_r == 2'd1) begin
      pend1_r <= data_byte;
    end
  end

  `SYSEX_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, count_r != 2'd3, "pending count overflow")
  `SYSEX_ASSERT_NEXT(a_msg_restart, clk, rst_n, accept && is_last,
                     count_r == 2'd0 && first_r, "message end did not restart grouping")
  `SYSEX_ASSERT_NOW(a_hold_silent, clk, rst_n, accept && !is_last && count_r != 2'd2,
                    !pkt_valid, "packet formed for a held byte")

endmodule

// ===== rtl/core/sysex_usb_midi_packetizer.sv =====
// Top level of the SysEx to USB-MIDI event packet packetizer.
//
//   channel  dir  fields                                              handshake
//   in_ch    in   data_byte[7:0], is_last                             valid/ready
//   out_ch   out  header[4:0], byte_one, byte_two, byte_three,        valid/ready
//                 last_packet
//   cfg_*    in   cfg_wr_data = cable_number                          cfg_wr_en
//
// One word accepted per cycle while in_ch.ready is high; a packet appears the cycle after
// the word that completes it, held in the single result register after the grouping logic.
// in_ch.ready falls only while a packet waits in the result register and out_ch.ready is low.
// Synchronous active-low reset clears pending count and cable number, sets first-group flag.
`include "sysex_usb_midi_packetizer_assert.svh"

module sysex_usb_midi_packetizer
  import sysex_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  sysex_byte_if.sink   in_ch,
  sysex_pkt_if.source  out_ch
);

  logic cable_r;
  logic in_acc;
  logic pkt_valid;
  pkt_t pkt;
  logic out_valid_r;
  pkt_t out_pkt_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  sysex_grouper u_grouper (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .data_byte (in_ch.data_byte),
    .is_last   (in_ch.is_last),
    .cable     (cable_r),
    .pkt_valid (pkt_valid),
    .pkt       (pkt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cable_r <= 1'b0;
    end else if (cfg_wr_en) begin
      cable_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= pkt_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && pkt_valid) begin
      out_pkt_r <= pkt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.header      = out_pkt_r.header;
  assign out_ch.byte_one    = out_pkt_r.byte_one;
  assign out_ch.byte_two    = out_pkt_r.byte_two;
  assign out_ch.byte_three  = out_pkt_r.byte_three;
  assign out_ch.last_packet = out_pkt_r.last_packet;

  `SYSEX_ASSERT_NEXT(a_pkt_loaded, clk, rst_n, in_acc && pkt_valid, out_valid_r,
                     "formed packet not registered")
  `SYSEX_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_valid_r && !out_ch.ready, !in_acc,
                    "word accepted over a waiting packet")
  `SYSEX_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && !out_ch.ready, out_valid_r,
                     "waiting packet dropped")

endmodule

// ===== bench/tb.sv =====
// Testbench for sysex_usb_midi_packetizer: random SysEx streams against a packet predictor.
`timescale 1ns / 100ps

module tb;
  import sysex_pkg::*;

  localparam int unsigned LONG_HOLD   = 150;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } sysex_word_t;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       cfg_wr_en   = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid    = 1'b0;
  logic [7:0] in_byte     = '0;
  logic       in_last     = 1'b0;
  logic       out_ready   = 1'b0;

  sysex_byte_if byte_ch ();
  sysex_pkt_if  pkt_ch ();

  assign byte_ch.valid     = in_valid;
  assign byte_ch.data_byte = in_byte;
  assign byte_ch.is_last   = in_last;
  assign pkt_ch.ready      = out_ready;

  sysex_usb_midi_packetizer u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (byte_ch),
    .out_ch      (pkt_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sysex_word_t bytes_to_send[$];
  pkt_t        packets_due[$];

  logic [7:0]  held_bytes[2];
  count_t      held_count    = '0;
  logic        opening_group = 1'b1;
  logic        cable_cfg     = 1'b0;

  bit          src_idle_on = 1'b1;
  bit          snk_idle_on = 1'b1;
  int unsigned src_gap     = 0;
  int unsigned snk_stall   = 0;
  int unsigned hold_req    = 0;
  int unsigned hold_served = 0;
  int unsigned mismatches  = 0;
  int unsigned cycles      = 0;

  task automatic pack_byte(input logic [7:0] b, input logic last);
    pkt_t p;
    p = '0;
    if (held_count == 2'd2) begin
      if (last) p.header = {cable_cfg, opening_group ? CIN_ONLY_THREE : CIN_END_THREE};
      else p.header = {cable_cfg, CIN_GROUP};
      p.byte_one    = held_bytes[0];
      p.byte_two    = held_bytes[1];
      p.byte_three  = b;
      p.last_packet = last;
      held_count    = '0;
      opening_group = last;
      packets_due.push_back(p);
    end else if (last) begin
      if (held_count == 2'd0) begin
        p.header   = {cable_cfg, CIN_END_ONE};
        p.byte_one = b;
      end else begin
        p.header   = {cable_cfg, CIN_END_TWO};
        p.byte_one = held_bytes[0];
        p.byte_two = b;
      end
      p.last_packet = 1'b1;
      held_count    = '0;
      opening_group = 1'b1;
      packets_due.push_back(p);
    end else begin
      held_bytes[held_count[0]] = b;
      held_count = held_count + 2'd1;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : drive
    sysex_word_t w;
    logic        nxt_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && byte_ch.ready) begin
        pack_byte(in_byte, in_last);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (bytes_to_send.size() > 0) begin
          if (src_idle_on && $urandom_range(0, 5) == 0) begin
            src_gap = $urandom_range(0, 16);
          end else begin
            w = bytes_to_send.pop_front();
            in_byte   <= w.data;
            in_last   <= w.last;
            nxt_valid = 1'b1;
          end
        end
      end
      in_valid <= nxt_valid;
    end
  end

  always @(posedge clk) begin : watch
    pkt_t got;
    pkt_t want;
    logic nxt_ready;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (pkt_ch.valid && out_ready) begin
        got.header      = pkt_ch.header;
        got.byte_one    = pkt_ch.byte_one;
        got.byte_two    = pkt_ch.byte_two;
        got.byte_three  = pkt_ch.byte_three;
        got.last_packet = pkt_ch.last_packet;
        if (packets_due.size() == 0) begin
          $error("packet: expected none, actual header %0h", got.header);
          mismatches++;
        end else begin
          want = packets_due.pop_front();
          check_field("header", 8'(want.header), 8'(got.header));
          check_field("byte_one", want.byte_one, got.byte_one);
          check_field("byte_two", want.byte_two, got.byte_two);
          check_field("byte_three", want.byte_three, got.byte_three);
          check_field("last_packet", 8'(want.last_packet), 8'(got.last_packet));
        end
      end
      if (hold_req != hold_served) begin
        hold_served = hold_req;
        snk_stall   = LONG_HOLD;
      end
      if (snk_stall > 0) begin
        snk_stall--;
        nxt_ready = 1'b0;
      end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
        snk_stall = $urandom_range(0, 16);
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      out_ready <= nxt_ready;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_word(input logic [7:0] data, input logic last);
    bytes_to_send.push_back({data, last});
  endtask

  task automatic queue_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) push_word(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  task automatic queue_messages(input int unsigned n_bytes);
    int unsigned total;
    int unsigned len;
    total = 0;
    while (total < n_bytes) begin
      if ($urandom_range(0, 9) < 7) len = $urandom_range(1, 9);
      else len = $urandom_range(10, 40);
      queue_message(len);
      total += len;
    end
  endtask

  task automatic wait_drained();
    while (bytes_to_send.size() != 0 || in_valid || packets_due.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cable(input logic value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cable_cfg   = value;
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    push_word(8'h00, 1'b1);
    push_word(8'hFF, 1'b0); push_word(8'h80, 1'b1);
    push_word(8'hF0, 1'b0); push_word(8'h55, 1'b0); push_word(8'hAA, 1'b1);
    push_word(8'h01, 1'b0); push_word(8'h7F, 1'b0); push_word(8'hFE, 1'b0);
    push_word(8'h40, 1'b1);
    push_word(8'h12, 1'b0); push_word(8'h34, 1'b0); push_word(8'h56, 1'b0);
    push_word(8'h78, 1'b0); push_word(8'h9A, 1'b0); push_word(8'hBC, 1'b1);
    push_word(8'hC3, 1'b0); push_word(8'h3C, 1'b0); push_word(8'h00, 1'b0);
    push_word(8'hFF, 1'b0); push_word(8'hF7, 1'b1);
    wait_drained();

    write_cable(1'b1);
    queue_messages(150);
    wait_drained();

    src_idle_on = 1'b0;
    hold_req++;
    queue_messages(100);
    wait_drained();

    write_cable(1'b0);
    src_idle_on = 1'b1;
    queue_messages(200);
    wait_drained();

    write_cable(1'b1);
    snk_idle_on = 1'b0;
    queue_messages(200);
    wait_drained();

    write_cable(1'b0);
    src_idle_on = 1'b0;
    queue_messages(200);
    wait_drained();

    repeat (10) @(posedge clk);
    if (mismatches == 0 && packets_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
